// ===== sv/gesp_pkg.sv =====
// Shared constants, command/status types and fixed-point helpers for the solver.
`timescale 1ns / 1ps
package gesp_pkg;

    localparam int ORDER  = 4;
    localparam int DW     = 32;
    localparam int FB     = 16;
    localparam int QW     = DW + FB;
    localparam int IDX_W  = $clog2(ORDER);
    localparam int COL_W  = $clog2(ORDER + 1);
    localparam int ADDR_W = IDX_W + COL_W;
    localparam int CNT_W  = $clog2(QW);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER - 1);
    localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(ORDER - 2);
    localparam logic [COL_W-1:0] RHS_COL  = COL_W'(ORDER);

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

    // datapath operations
    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_COPY    = 5'd2;
    localparam logic [4:0] OP_SC_RD   = 5'd3;
    localparam logic [4:0] OP_SC_ACC  = 5'd4;
    localparam logic [4:0] OP_PV_INIT = 5'd5;
    localparam logic [4:0] OP_PV_RD   = 5'd6;
    localparam logic [4:0] OP_PV_DS   = 5'd7;
    localparam logic [4:0] OP_PV_CMP  = 5'd8;
    localparam logic [4:0] OP_SWAP    = 5'd9;
    localparam logic [4:0] OP_PROW    = 5'd10;
    localparam logic [4:0] OP_PCHK    = 5'd11;
    localparam logic [4:0] OP_EL_RD   = 5'd12;
    localparam logic [4:0] OP_EL_DS   = 5'd13;
    localparam logic [4:0] OP_EL_MW   = 5'd14;
    localparam logic [4:0] OP_EL_RN   = 5'd15;
    localparam logic [4:0] OP_EL_MUL  = 5'd16;
    localparam logic [4:0] OP_EL_SUB  = 5'd17;
    localparam logic [4:0] OP_LS_RD   = 5'd18;
    localparam logic [4:0] OP_FW_RD1  = 5'd19;
    localparam logic [4:0] OP_FW_RD2  = 5'd20;
    localparam logic [4:0] OP_FW_MUL  = 5'd21;
    localparam logic [4:0] OP_FW_SUB  = 5'd22;
    localparam logic [4:0] OP_BK_RD   = 5'd23;
    localparam logic [4:0] OP_BK_LD   = 5'd24;
    localparam logic [4:0] OP_BK_RN   = 5'd25;
    localparam logic [4:0] OP_BK_MUL  = 5'd26;
    localparam logic [4:0] OP_BK_SUB  = 5'd27;
    localparam logic [4:0] OP_BK_RP   = 5'd28;
    localparam logic [4:0] OP_BK_DS   = 5'd29;
    localparam logic [4:0] OP_BK_WR   = 5'd30;
    localparam logic [4:0] OP_CLR     = 5'd31;

    typedef struct packed {
        logic [4:0]        op;
        logic [IDX_W-1:0]  j;
        logic [IDX_W-1:0]  k;
        logic [IDX_W-1:0]  m;
        logic [IDX_W-1:0]  n;
        logic [ADDR_W-1:0] caddr;
        logic              out_ld;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic rs_zero;
        logic wq_zero;
    } stat_t;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
        return a[DW-1] ? DW'(0) - DW'(a) : DW'(a);
    endfunction

    function automatic logic signed [DW-1:0] abs_sat(input logic signed [DW-1:0] a);
        return (a == VMIN) ? VMAX : $signed(mag(a));
    endfunction

    // sign plus magnitude to a saturated value
    function automatic logic signed [DW-1:0] sat_mag(input logic neg,
                                                     input logic [QW-1:0] m);
        logic [QW-1:0] lim;
        lim = {{(QW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
        if (neg)
            return (m >= lim) ? VMIN : $signed(DW'(0) - m[DW-1:0]);
        return (m >= lim) ? VMAX : $signed(m[DW-1:0]);
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] d;
        d = {a[DW-1], a} - {b[DW-1], b};
        if (d[DW] != d[DW-1])
            return d[DW] ? VMIN : VMAX;
        return d[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] fx_mul(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
        logic [2*DW-1:0] p;
        p = mag(a) * mag(b);
        return sat_mag(a[DW-1] ^ b[DW-1], p[FB +: QW]);
    endfunction

endpackage

// ===== sv/linear_system_solver_scaled_pivot.sv =====
// Top level of the scaled-partial-pivoting linear system solver.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready): one word per matrix element, giving
//   row, col (col 4 is the right-hand side), a Q16.16 value and last. Words
//   load at one per cycle into the element store; columns above 4 are dropped.
//   A word with last set is stored (unless its column is dropped) and then starts the solve.
//   Output channel (out_valid/out_ready): four words, var_index 0..3, with the
//   Q16.16 solution, the singular flag and final_res on the fourth word.
// Solve sequence
//   The solve is dominated by the radix-2 divider, 48 quotient bits per call,
//   used up to 19 times (9 pivot ratios, 6 multipliers, 4 back-substitution
//   quotients); the rest goes to the working matrix, with one read and one
//   write port, and a copy pass over all 32 element-store words.
//   A zero pivot ends the solve early with all-zero results.
//   Results then leave at one word per cycle while out_ready is high.
// Reset and stall
//   rst_n clears the sequencer, row order and scales; stored elements are
//   undefined until loaded. in_ready is low from the last word until the last
//   result is taken. A stalled receiver holds the current result word steady.
module linear_system_solver_scaled_pivot (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [gesp_pkg::IDX_W-1:0]           row,
    input  logic [gesp_pkg::COL_W-1:0]           col,
    input  logic signed [gesp_pkg::DW-1:0]       value,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gesp_pkg::IDX_W-1:0]           var_index,
    output logic signed [gesp_pkg::DW-1:0]       solution,
    output logic                                 singular,
    output logic                                 final_res
);
    gesp_pkg::cmd_t  cmd;
    gesp_pkg::stat_t st;

    // sequencer: owns handshakes and loop indices
    gesp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: stores, divider, multiply/subtract, output word register
    gesp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .row       (row),
        .col       (col),
        .value     (value),
        .last      (last),
        .var_index (var_index),
        .solution  (solution),
        .singular  (singular),
        .final_res (final_res)
    );
endmodule

// ===== sv/gesp_div.sv =====
// Restoring fixed-point divider, one quotient bit per cycle, saturated result.
`timescale 1ns / 1ps
module gesp_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [gesp_pkg::DW-1:0]  a,
    input  logic signed [gesp_pkg::DW-1:0]  b,
    output logic                            done,
    output logic signed [gesp_pkg::DW-1:0]  q
);
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [gesp_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [gesp_pkg::QW-1:0]        num_reg, num_next;
    logic [gesp_pkg::DW-1:0]        rem_reg, rem_next;
    logic [gesp_pkg::DW-1:0]        den_reg, den_next;
    logic                           neg_reg, neg_next;
    logic [gesp_pkg::DW:0]          trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, num_reg[gesp_pkg::QW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = {gesp_pkg::mag(a), {gesp_pkg::FB{1'b0}}};
            rem_next  = '0;
            den_next  = gesp_pkg::mag(b);
            neg_next  = a[gesp_pkg::DW-1] ^ b[gesp_pkg::DW-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = gesp_pkg::DW'(trial - {1'b0, den_reg});
                num_next = {num_reg[gesp_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[gesp_pkg::DW-1:0];
                num_next = {num_reg[gesp_pkg::QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gesp_pkg::CNT_W'(gesp_pkg::QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign q    = gesp_pkg::sat_mag(neg_reg, num_reg);
endmodule

// ===== sv/gesp_datapath.sv =====
// Solver datapath: element stores, working matrix, row order, scales and arithmetic.
`timescale 1ns / 1ps
module gesp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gesp_pkg::cmd_t                    cmd,
    output gesp_pkg::stat_t                   st,
    input  logic [gesp_pkg::IDX_W-1:0]        row,
    input  logic [gesp_pkg::COL_W-1:0]        col,
    input  logic signed [gesp_pkg::DW-1:0]    value,
    input  logic                              last,
    output logic [gesp_pkg::IDX_W-1:0]        var_index,
    output logic signed [gesp_pkg::DW-1:0]    solution,
    output logic                              singular,
    output logic                              final_res
);
    localparam int NW = 1 << gesp_pkg::ADDR_W;
    localparam int DW = gesp_pkg::DW;
    localparam int IW = gesp_pkg::IDX_W;
    localparam int CW = gesp_pkg::COL_W;

    logic signed [DW-1:0] sm [NW];
    logic signed [DW-1:0] wm [NW];
    logic signed [DW-1:0] sq_reg;
    logic signed [DW-1:0] wq_reg;
    logic                 cp_pend_reg;
    logic [gesp_pkg::ADDR_W-1:0] cp_addr_reg;

    logic [IW-1:0]        ord_reg [gesp_pkg::ORDER];
    logic signed [DW-1:0] scl_reg [gesp_pkg::ORDER];
    logic signed [DW-1:0] sol_reg [gesp_pkg::ORDER];
    logic                 sing_reg;

    logic signed [DW-1:0] acc_reg, rs_reg, piv_reg, mult_reg, mulr_reg, t1_reg;
    logic [DW-1:0]        best_reg;
    logic [IW-1:0]        pick_reg, prow_reg, rm_reg;

    logic                 rd_en, we, div_go, div_done;
    logic [gesp_pkg::ADDR_W-1:0] rd_addr, wa;
    logic signed [DW-1:0] wd, div_a, div_b, divq, s_new;
    logic [DW-1:0]        rat;

    function automatic logic [gesp_pkg::ADDR_W-1:0] ad(input logic [IW-1:0] r,
                                                       input logic [CW-1:0] c);
        return {r, c};
    endfunction

    gesp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .q     (divq)
    );

    assign s_new = (cmd.n == '0) ? gesp_pkg::abs_sat(wq_reg)
                 : ((gesp_pkg::abs_sat(wq_reg) > acc_reg) ? gesp_pkg::abs_sat(wq_reg)
                                                          : acc_reg);
    assign rat = (rs_reg == '0) ? '0 : gesp_pkg::mag(divq);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        we      = 1'b0;
        wa      = '0;
        wd      = '0;
        div_go  = 1'b0;
        div_a   = wq_reg;
        div_b   = piv_reg;
        unique case (cmd.op)
            gesp_pkg::OP_SC_RD:
            begin
                rd_en = 1'b1; rd_addr = ad(cmd.j, CW'(cmd.n));
            end
            gesp_pkg::OP_PV_RD:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.k], CW'(cmd.j));
            end
            gesp_pkg::OP_PV_DS:
            begin
                div_go = (rs_reg != '0); div_b = rs_reg;
            end
            gesp_pkg::OP_PROW:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.j], CW'(cmd.j));
            end
            gesp_pkg::OP_EL_RD:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.m], CW'(cmd.j));
            end
            gesp_pkg::OP_EL_DS:
            begin
                div_go = 1'b1;
            end
            gesp_pkg::OP_EL_MW:
            begin
                we = 1'b1; wa = ad(rm_reg, CW'(cmd.j)); wd = divq;
            end
            gesp_pkg::OP_EL_RN:
            begin
                rd_en = 1'b1; rd_addr = ad(prow_reg, CW'(cmd.n));
            end
            gesp_pkg::OP_EL_MUL:
            begin
                rd_en = 1'b1; rd_addr = ad(rm_reg, CW'(cmd.n));
            end
            gesp_pkg::OP_EL_SUB:
            begin
                we = 1'b1; wa = ad(rm_reg, CW'(cmd.n));
                wd = gesp_pkg::sat_sub(wq_reg, mulr_reg);
            end
            gesp_pkg::OP_LS_RD:
            begin
                rd_en = 1'b1;
                rd_addr = ad(ord_reg[gesp_pkg::LAST_IDX], CW'(gesp_pkg::LAST_IDX));
            end
            gesp_pkg::OP_FW_RD1:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.j], gesp_pkg::RHS_COL);
            end
            gesp_pkg::OP_FW_RD2:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.m], CW'(cmd.j));
            end
            gesp_pkg::OP_FW_MUL:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.m], gesp_pkg::RHS_COL);
            end
            gesp_pkg::OP_FW_SUB:
            begin
                we = 1'b1; wa = ad(ord_reg[cmd.m], gesp_pkg::RHS_COL);
                wd = gesp_pkg::sat_sub(wq_reg, mulr_reg);
            end
            gesp_pkg::OP_BK_RD:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.k], gesp_pkg::RHS_COL);
            end
            gesp_pkg::OP_BK_RN:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.k], CW'(cmd.n));
            end
            gesp_pkg::OP_BK_RP:
            begin
                rd_en = 1'b1; rd_addr = ad(ord_reg[cmd.k], CW'(cmd.k));
            end
            gesp_pkg::OP_BK_DS:
            begin
                div_go = 1'b1; div_a = acc_reg; div_b = wq_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
        // pending copy word owns the write port
        if (cp_pend_reg)
        begin
            we = 1'b1; wa = cp_addr_reg; wd = sq_reg;
        end
    end

    // element store and working matrix
    always_ff @(posedge clk)
    begin
        if (cmd.op == gesp_pkg::OP_LOAD && col <= gesp_pkg::RHS_COL)
            sm[ad(row, col)] <= value;
        if (cmd.op == gesp_pkg::OP_COPY)
            sq_reg <= sm[cmd.caddr];
        if (we)
            wm[wa] <= wd;
        if (rd_en)
            wq_reg <= wm[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_pend_reg <= 1'b0;
            sing_reg    <= 1'b0;
            for (int i = 0; i < gesp_pkg::ORDER; i++)
            begin
                ord_reg[i] <= IW'(i);
                scl_reg[i] <= '0;
            end
        end
        else
        begin
            cp_pend_reg <= (cmd.op == gesp_pkg::OP_COPY);
            if (cmd.op == gesp_pkg::OP_LOAD && last)
                sing_reg <= 1'b0;
            if (cmd.op == gesp_pkg::OP_CLR)
                sing_reg <= 1'b1;
            if (cmd.op == gesp_pkg::OP_SC_RD)
                ord_reg[cmd.j] <= cmd.j;
            if (cmd.op == gesp_pkg::OP_SC_ACC && cmd.n == gesp_pkg::LAST_IDX)
                scl_reg[cmd.j] <= s_new;
            // pivot already in place needs no exchange
            if (cmd.op == gesp_pkg::OP_SWAP && pick_reg != cmd.j)
            begin
                ord_reg[pick_reg] <= ord_reg[cmd.j];
                ord_reg[cmd.j]    <= ord_reg[pick_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg <= cmd.caddr;
        unique case (cmd.op)
            gesp_pkg::OP_SC_ACC:  acc_reg <= s_new;
            gesp_pkg::OP_PV_INIT:
            begin
                best_reg <= '0; pick_reg <= cmd.j;
            end
            gesp_pkg::OP_PV_RD:   rs_reg <= scl_reg[ord_reg[cmd.k]];
            gesp_pkg::OP_PV_CMP:
            begin
                if (rat > best_reg)
                begin
                    best_reg <= rat; pick_reg <= cmd.k;
                end
            end
            gesp_pkg::OP_PROW:    prow_reg <= ord_reg[cmd.j];
            gesp_pkg::OP_PCHK:    piv_reg <= wq_reg;
            gesp_pkg::OP_EL_RD:   rm_reg <= ord_reg[cmd.m];
            gesp_pkg::OP_EL_MW:   mult_reg <= divq;
            gesp_pkg::OP_EL_MUL:  mulr_reg <= gesp_pkg::fx_mul(mult_reg, wq_reg);
            gesp_pkg::OP_FW_RD2:  t1_reg <= wq_reg;
            gesp_pkg::OP_FW_MUL:  mulr_reg <= gesp_pkg::fx_mul(wq_reg, t1_reg);
            gesp_pkg::OP_BK_LD:   acc_reg <= wq_reg;
            gesp_pkg::OP_BK_MUL:  mulr_reg <= gesp_pkg::fx_mul(wq_reg, sol_reg[cmd.n]);
            gesp_pkg::OP_BK_SUB:  acc_reg <= gesp_pkg::sat_sub(acc_reg, mulr_reg);
            gesp_pkg::OP_BK_WR:   sol_reg[cmd.k] <= divq;
            gesp_pkg::OP_CLR:
            begin
                for (int i = 0; i < gesp_pkg::ORDER; i++)
                    sol_reg[i] <= '0;
            end
            default:
            begin
            end
        endcase
        if (cmd.out_ld)
        begin
            var_index <= cmd.k;
            solution  <= sol_reg[cmd.k];
            singular  <= sing_reg;
            final_res <= (cmd.k == gesp_pkg::LAST_IDX);
        end
    end

    assign st.div_done = div_done;
    assign st.rs_zero  = (rs_reg == '0);
    assign st.wq_zero  = (wq_reg == '0);
endmodule

// ===== sv/gesp_ctrl.sv =====
// Solver sequencer: loop counters and state machine driving the datapath.
`timescale 1ns / 1ps
module gesp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  gesp_pkg::stat_t      st,
    output gesp_pkg::cmd_t       cmd
);
    localparam int IW = gesp_pkg::IDX_W;
    localparam int AW = gesp_pkg::ADDR_W;

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_COPY  = 6'd1;
    localparam logic [5:0] S_SCRD  = 6'd2;
    localparam logic [5:0] S_SCACC = 6'd3;
    localparam logic [5:0] S_PINIT = 6'd4;
    localparam logic [5:0] S_PRD   = 6'd5;
    localparam logic [5:0] S_PDS   = 6'd6;
    localparam logic [5:0] S_PDW   = 6'd7;
    localparam logic [5:0] S_PCMP  = 6'd8;
    localparam logic [5:0] S_SWAP  = 6'd9;
    localparam logic [5:0] S_PROW  = 6'd10;
    localparam logic [5:0] S_PCHK  = 6'd11;
    localparam logic [5:0] S_ERD   = 6'd12;
    localparam logic [5:0] S_EDS   = 6'd13;
    localparam logic [5:0] S_EDW   = 6'd14;
    localparam logic [5:0] S_EMW   = 6'd15;
    localparam logic [5:0] S_ERN   = 6'd16;
    localparam logic [5:0] S_EMUL  = 6'd17;
    localparam logic [5:0] S_ESUB  = 6'd18;
    localparam logic [5:0] S_LSRD  = 6'd19;
    localparam logic [5:0] S_LSCHK = 6'd20;
    localparam logic [5:0] S_FRD1  = 6'd21;
    localparam logic [5:0] S_FRD2  = 6'd22;
    localparam logic [5:0] S_FMUL  = 6'd23;
    localparam logic [5:0] S_FSUB  = 6'd24;
    localparam logic [5:0] S_BRD   = 6'd25;
    localparam logic [5:0] S_BLD   = 6'd26;
    localparam logic [5:0] S_BRN   = 6'd27;
    localparam logic [5:0] S_BMUL  = 6'd28;
    localparam logic [5:0] S_BSUB  = 6'd29;
    localparam logic [5:0] S_BRP   = 6'd30;
    localparam logic [5:0] S_BDS   = 6'd31;
    localparam logic [5:0] S_BDW   = 6'd32;
    localparam logic [5:0] S_BWR   = 6'd33;
    localparam logic [5:0] S_CLR   = 6'd34;
    localparam logic [5:0] S_OLD   = 6'd35;
    localparam logic [5:0] S_OSH   = 6'd36;

    logic [5:0]    state_reg, state_next;
    logic [IW-1:0] j_reg, j_next, k_reg, k_next, m_reg, m_next, n_reg, n_next;
    logic [AW-1:0] c_reg, c_next;
    logic          ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        j_next = j_reg; k_next = k_reg; m_next = m_reg; n_next = n_reg;
        c_next = c_reg;
        ov_next = ov_reg;
        cmd.op = gesp_pkg::OP_NOP;
        cmd.j = j_reg; cmd.k = k_reg; cmd.m = m_reg; cmd.n = n_reg;
        cmd.caddr = c_reg;
        cmd.out_ld = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = gesp_pkg::OP_LOAD;
                    if (last)
                    begin
                        c_next = '0;
                        state_next = S_COPY;
                    end
                end
            end
            S_COPY:
            begin
                cmd.op = gesp_pkg::OP_COPY;
                c_next = c_reg + 1'b1;
                if (c_reg == '1)
                begin
                    j_next = '0; n_next = '0;
                    state_next = S_SCRD;
                end
            end
            S_SCRD:
            begin
                cmd.op = gesp_pkg::OP_SC_RD;
                state_next = S_SCACC;
            end
            S_SCACC:
            begin
                cmd.op = gesp_pkg::OP_SC_ACC;
                state_next = S_SCRD;
                if (n_reg == gesp_pkg::LAST_IDX)
                begin
                    n_next = '0;
                    j_next = j_reg + 1'b1;
                    if (j_reg == gesp_pkg::LAST_IDX)
                    begin
                        j_next = '0;
                        state_next = S_PINIT;
                    end
                end
                else
                    n_next = n_reg + 1'b1;
            end
            S_PINIT:
            begin
                cmd.op = gesp_pkg::OP_PV_INIT;
                k_next = j_reg;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                cmd.op = gesp_pkg::OP_PV_RD;
                state_next = S_PDS;
            end
            S_PDS:
            begin
                cmd.op = gesp_pkg::OP_PV_DS;
                state_next = st.rs_zero ? S_PCMP : S_PDW;
            end
            S_PDW:
            begin
                if (st.div_done)
                    state_next = S_PCMP;
            end
            S_PCMP:
            begin
                cmd.op = gesp_pkg::OP_PV_CMP;
                if (k_reg == gesp_pkg::LAST_IDX)
                    state_next = S_SWAP;
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_PRD;
                end
            end
            S_SWAP:
            begin
                cmd.op = gesp_pkg::OP_SWAP;
                state_next = S_PROW;
            end
            S_PROW:
            begin
                cmd.op = gesp_pkg::OP_PROW;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                cmd.op = gesp_pkg::OP_PCHK;
                m_next = j_reg + 1'b1;
                state_next = st.wq_zero ? S_CLR : S_ERD;
            end
            S_ERD:
            begin
                cmd.op = gesp_pkg::OP_EL_RD;
                state_next = S_EDS;
            end
            S_EDS:
            begin
                cmd.op = gesp_pkg::OP_EL_DS;
                state_next = S_EDW;
            end
            S_EDW:
            begin
                if (st.div_done)
                    state_next = S_EMW;
            end
            S_EMW:
            begin
                cmd.op = gesp_pkg::OP_EL_MW;
                n_next = j_reg + 1'b1;
                state_next = S_ERN;
            end
            S_ERN:
            begin
                cmd.op = gesp_pkg::OP_EL_RN;
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.op = gesp_pkg::OP_EL_MUL;
                state_next = S_ESUB;
            end
            S_ESUB:
            begin
                cmd.op = gesp_pkg::OP_EL_SUB;
                if (n_reg != gesp_pkg::LAST_IDX)
                begin
                    n_next = n_reg + 1'b1;
                    state_next = S_ERN;
                end
                else if (m_reg != gesp_pkg::LAST_IDX)
                begin
                    m_next = m_reg + 1'b1;
                    state_next = S_ERD;
                end
                else if (j_reg != gesp_pkg::PEN_IDX)
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_PINIT;
                end
                else
                    state_next = S_LSRD;
            end
            S_LSRD:
            begin
                cmd.op = gesp_pkg::OP_LS_RD;
                state_next = S_LSCHK;
            end
            S_LSCHK:
            begin
                j_next = '0;
                m_next = IW'(1);
                state_next = st.wq_zero ? S_CLR : S_FRD1;
            end
            S_FRD1:
            begin
                cmd.op = gesp_pkg::OP_FW_RD1;
                state_next = S_FRD2;
            end
            S_FRD2:
            begin
                cmd.op = gesp_pkg::OP_FW_RD2;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.op = gesp_pkg::OP_FW_MUL;
                state_next = S_FSUB;
            end
            S_FSUB:
            begin
                cmd.op = gesp_pkg::OP_FW_SUB;
                if (m_reg != gesp_pkg::LAST_IDX)
                begin
                    m_next = m_reg + 1'b1;
                    state_next = S_FRD1;
                end
                else if (j_reg != gesp_pkg::PEN_IDX)
                begin
                    j_next = j_reg + 1'b1;
                    m_next = j_reg + IW'(2);
                    state_next = S_FRD1;
                end
                else
                begin
                    k_next = gesp_pkg::LAST_IDX;
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                cmd.op = gesp_pkg::OP_BK_RD;
                state_next = S_BLD;
            end
            S_BLD:
            begin
                cmd.op = gesp_pkg::OP_BK_LD;
                n_next = k_reg + 1'b1;
                state_next = (k_reg == gesp_pkg::LAST_IDX) ? S_BRP : S_BRN;
            end
            S_BRN:
            begin
                cmd.op = gesp_pkg::OP_BK_RN;
                state_next = S_BMUL;
            end
            S_BMUL:
            begin
                cmd.op = gesp_pkg::OP_BK_MUL;
                state_next = S_BSUB;
            end
            S_BSUB:
            begin
                cmd.op = gesp_pkg::OP_BK_SUB;
                if (n_reg == gesp_pkg::LAST_IDX)
                    state_next = S_BRP;
                else
                begin
                    n_next = n_reg + 1'b1;
                    state_next = S_BRN;
                end
            end
            S_BRP:
            begin
                cmd.op = gesp_pkg::OP_BK_RP;
                state_next = S_BDS;
            end
            S_BDS:
            begin
                cmd.op = gesp_pkg::OP_BK_DS;
                state_next = S_BDW;
            end
            S_BDW:
            begin
                if (st.div_done)
                    state_next = S_BWR;
            end
            S_BWR:
            begin
                cmd.op = gesp_pkg::OP_BK_WR;
                if (k_reg == '0)
                    state_next = S_OLD;
                else
                begin
                    k_next = k_reg - 1'b1;
                    state_next = S_BRD;
                end
            end
            S_CLR:
            begin
                cmd.op = gesp_pkg::OP_CLR;
                k_next = '0;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                cmd.k = '0;
                cmd.out_ld = 1'b1;
                k_next = '0;
                ov_next = 1'b1;
                state_next = S_OSH;
            end
            S_OSH:
            begin
                if (out_ready)
                begin
                    if (k_reg == gesp_pkg::LAST_IDX)
                    begin
                        ov_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        cmd.k = k_reg + 1'b1;
                        cmd.out_ld = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ov_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg <= '0; k_reg <= '0; m_reg <= '0; n_reg <= '0;
            c_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg <= j_next; k_reg <= k_next; m_reg <= m_next; n_reg <= n_next;
            c_reg <= c_next;
            ov_reg <= ov_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
endmodule

// ===== sv/gesp_chk.sv =====
// Port-level checker for the solver, bound to the top level.
`timescale 1ns / 1ps
module gesp_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [gesp_pkg::IDX_W-1:0]      var_index,
    input logic signed [gesp_pkg::DW-1:0]  solution,
    input logic                            singular,
    input logic                            final_res
);
    // never loading while results are pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while results pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(solution) && $stable(var_index))
        else $error("stalled result changed");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_res |=>
            out_valid && var_index == $past(var_index) + 1'b1)
        else $error("result words out of order");

    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_res |-> var_index == gesp_pkg::LAST_IDX)
        else $error("final word on wrong index");

    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> solution == '0)
        else $error("singular run gave nonzero result");
endmodule

bind linear_system_solver_scaled_pivot gesp_chk u_gesp_chk (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the scaled-pivot Gaussian elimination solver.
`timescale 1ns / 1ps

// Keeps a copy of the element stores and predicts the solution words
// that each solve should produce.
class solve_scoreboard;
    typedef struct {
        logic [1:0]  idx;
        logic [31:0] sol;
        logic        sing;
        logic        fin;
    } sol_word_t;

    longint    elem[4][4];
    longint    rhs[4];
    longint    sol_mem[4];
    sol_word_t pending_q[$];
    int        errors;

    function new();
        errors = 0;
        foreach (sol_mem[i]) sol_mem[i] = 0;
    endfunction

    static function longint clamp(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function longint magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    static function longint sub_sat(longint a, longint b);
        return clamp(a - b);
    endfunction

    // operand magnitudes stay at or under 2^31, so 64 bits hold the full product
    static function longint mul_q(longint a, longint b);
        longint p;
        p = (magn(a) * magn(b)) >>> 16;
        return clamp(((a < 0) != (b < 0)) ? -p : p);
    endfunction

    static function longint div_q(longint a, longint b);
        longint q;
        q = (magn(a) <<< 16) / magn(b);
        return clamp(((a < 0) != (b < 0)) ? -q : q);
    endfunction

    // returns 1 on a zero pivot
    function bit run_solve();
        longint w[4][4];
        longint bv[4];
        longint scl[4];
        int     ord[4];
        longint best, rat, piv, mult, sum, t;
        int     pick, tmp;
        w = elem;
        bv = rhs;
        for (int h = 0; h < 4; h++)
        begin
            ord[h] = h;
            scl[h] = 0;
            for (int i = 0; i < 4; i++)
            begin
                t = clamp(magn(w[h][i]));
                if (t > scl[h]) scl[h] = t;
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            best = 0;
            pick = j;
            for (int k = j; k < 4; k++)
            begin
                rat = (scl[ord[k]] != 0) ? magn(div_q(w[ord[k]][j], scl[ord[k]])) : 0;
                if (rat > best)
                begin
                    best = rat;
                    pick = k;
                end
            end
            tmp = ord[pick];
            ord[pick] = ord[j];
            ord[j] = tmp;
            piv = w[ord[j]][j];
            if (piv == 0) return 1;
            for (int m = j + 1; m < 4; m++)
            begin
                mult = div_q(w[ord[m]][j], piv);
                w[ord[m]][j] = mult;
                for (int n = j + 1; n < 4; n++)
                    w[ord[m]][n] = sub_sat(w[ord[m]][n], mul_q(mult, w[ord[j]][n]));
            end
        end
        if (w[ord[3]][3] == 0) return 1;
        for (int i = 0; i < 3; i++)
            for (int j = i + 1; j < 4; j++)
                bv[ord[j]] = sub_sat(bv[ord[j]], mul_q(w[ord[j]][i], bv[ord[i]]));
        for (int k = 3; k >= 0; k--)
        begin
            sum = bv[ord[k]];
            for (int n = k + 1; n < 4; n++)
                sum = sub_sat(sum, mul_q(w[ord[k]][n], sol_mem[n]));
            sol_mem[k] = div_q(sum, w[ord[k]][k]);
        end
        return 0;
    endfunction

    function void note_word(logic [1:0] r, logic [2:0] c, logic signed [31:0] v, logic l);
        bit        sing;
        sol_word_t e;
        if (c < gesp_pkg::ORDER) elem[r][c] = longint'(v);
        else if (c == gesp_pkg::RHS_COL) rhs[r] = longint'(v);
        if (!l) return;
        sing = run_solve();
        if (sing) foreach (sol_mem[i]) sol_mem[i] = 0;
        for (int k = 0; k < 4; k++)
        begin
            e.idx = 2'(k);
            e.sol = 32'(sol_mem[k]);
            e.sing = sing;
            e.fin = (k == 3);
            pending_q.push_back(e);
        end
    endfunction

    function void check_word(logic [1:0] idx, logic [31:0] sol, logic sing, logic fin);
        sol_word_t e;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result word idx=%0d sol=%h", $time, idx, sol);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (idx !== e.idx || sol !== e.sol || sing !== e.sing || fin !== e.fin)
        begin
            $display("%0t: mismatch exp idx=%0d sol=%h sing=%0b fin=%0b", $time,
                     e.idx, e.sol, e.sing, e.fin);
            $display("%0t:          got idx=%0d sol=%h sing=%0b fin=%0b", $time,
                     idx, sol, sing, fin);
            errors++;
        end
    endfunction
endclass

module tb_top;
    typedef enum int { MAT_RANDOM, MAT_IDENT, MAT_EXTREME, MAT_ZERO_ROW, MAT_DUP_ROW } mat_kind_t;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [1:0]         row = 0;
    logic [2:0]         col = 0;
    logic signed [31:0] value = 0;
    logic               last = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [1:0]         var_index;
    logic signed [31:0] solution;
    logic               singular;
    logic               final_res;

    solve_scoreboard sb = new();
    int              words_sent = 0;
    bit              no_idle = 0;   // toggled to get stretches with no gaps

    always #10 clk = ~clk;

    linear_system_solver_scaled_pivot u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .row(row), .col(col), .value(value), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .var_index(var_index), .solution(solution),
        .singular(singular), .final_res(final_res)
    );

    // mostly short gaps, occasionally a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return $urandom_range(0, 1 << 21) - (1 << 20);  // within +/-16
        if (p < 65) return ($urandom_range(0, 16) - 8) <<< 16;      // whole numbers
        if (p < 85) return $urandom();
        if (p < 90) return 32'h8000_0000;
        if (p < 95) return 32'h7fff_ffff;
        return 0;
    endfunction

    // one input word, held until accepted
    task automatic send_word(logic [1:0] r, logic [2:0] c, logic [31:0] v, logic l);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid = 0;
            repeat (g) @(negedge clk);
        end
        row = r;
        col = c;
        value = v;
        last = l;
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        sb.note_word(r, c, v, l);
        if (c <= gesp_pkg::RHS_COL) words_sent++;
        @(negedge clk);
        in_valid = 0;
    endtask

    // full load of all 20 entries in shuffled order, last on the final one
    task automatic load_matrix(mat_kind_t kind);
        logic [31:0] m[4][5];
        int          ord[20];
        int          t, s;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 5; c++)
            begin
                case (kind)
                    MAT_IDENT:   m[r][c] = (c == r) ? 32'h0002_0000 : (c == 4 ? pick_value() : 0);
                    MAT_EXTREME: m[r][c] = ((r + c) % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
                    default:     m[r][c] = pick_value();
                endcase
            end
        if (kind == MAT_ZERO_ROW)
        begin
            t = $urandom_range(0, 3);
            for (int c = 0; c < 4; c++) m[t][c] = 0;
        end
        if (kind == MAT_DUP_ROW)
        begin
            t = $urandom_range(0, 2);
            for (int c = 0; c < 4; c++) m[t + 1][c] = m[t][c];
        end
        for (int i = 0; i < 20; i++) ord[i] = i;
        for (int i = 19; i > 0; i--)
        begin
            s = $urandom_range(0, i);
            t = ord[i]; ord[i] = ord[s]; ord[s] = t;
        end
        for (int i = 0; i < 20; i++)
        begin
            // an ignored column now and then
            if ($urandom_range(0, 15) == 0)
                send_word(2'($urandom()), 3'($urandom_range(5, 7)), $urandom(), 1'b0);
            send_word(2'(ord[i] / 5), 3'(ord[i] % 5), m[ord[i] / 5][ord[i] % 5], i == 19);
        end
    endtask

    // a few stored entries changed, then a new solve
    task automatic patch_entries();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            send_word(2'($urandom()), 3'($urandom_range(0, 4)), pick_value(), i == n - 1);
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed part
        no_idle = 1;
        load_matrix(MAT_IDENT);
        no_idle = 0;
        send_word(2'd3, 3'd4, 32'h8000_0000, 1'b0);
        send_word(2'd0, 3'd0, 32'h7fff_ffff, 1'b0);
        send_word(2'd1, 3'd7, 32'hffff_ffff, 1'b1);   // ignored column still starts solve
        load_matrix(MAT_EXTREME);
        load_matrix(MAT_ZERO_ROW);

        // random part
        while (words_sent < 420)
        begin
            int p;
            p = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
            if (p < 35) load_matrix(MAT_RANDOM);
            else if (p < 42) load_matrix(MAT_DUP_ROW);
            else if (p < 47) load_matrix(MAT_ZERO_ROW);
            else if (p < 90) patch_entries();
            else send_word(2'($urandom()), 3'($urandom_range(5, 7)), $urandom(),
                           1'($urandom_range(0, 1)));
        end

        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, with stretches of none
    initial
    begin
        int g;
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g > 0)
            begin
                out_ready = 0;
                repeat (g) @(negedge clk);
            end
            out_ready = 1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_word(var_index, solution, singular, final_res);

    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end
endmodule
